@@ sv/keyed_quota_rate_limit_table_macros.svh @@
// Assertion macros used by the checker file.
// Include guard keeps repeated inclusion harmless.
`ifndef KEYED_QUOTA_RATE_LIMIT_TABLE_MACROS_SVH
`define KEYED_QUOTA_RATE_LIMIT_TABLE_MACROS_SVH
// Checks that an antecedent implies a consequent at the same edge.
`define KQ_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Checks that an antecedent implies a consequent at the next edge.
`define KQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ sv/kqrl_pkg.sv @@
// Package for the keyed quota and rate-limit table.
// Holds operation and status codes and default sizes; no dependencies.
package kqrl_pkg;
  localparam int DefMaxEntries = 256;
  localparam int DefKeyBits = 64;
  localparam logic [15:0] WindowReset = 16'd60;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0, OP_GET = 3'd1, OP_UPDATE = 3'd2, OP_DELETE = 3'd3,
    OP_ADD = 3'd4, OP_CHK_QUOTA = 3'd5, OP_CHK_RATE = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_KEY = 3'd1, ST_EXISTS = 3'd2, ST_FULL = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  // Record without its key, as stored in the data memory.
  typedef struct packed {
    logic [63:0] quota;
    logic [63:0] usage;
    logic [19:0] limit;
    logic [31:0] wstart;
    logic [19:0] wcount;
  } rec_t;
endpackage

@@ sv/kqrl_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
// No package dependencies.
module kqrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/keyed_quota_rate_limit_table.sv @@
// Keyed quota and rate-limit table with a sequential key search.
// The search visits the entries in order, each through S_SCAN, S_WAITK and S_CMP; the record
// is then read in S_RD and S_RDW (and S_OUT for a delete), and S_EXEC writes the result word.
// One word is in work at a time; the next is taken once the block is idle.
// An unread result waits in the output register; only the next operation's last step waits.
// Reset (synchronous, active high) empties the table and sets the window to 60.
module keyed_quota_rate_limit_table
  import kqrl_pkg::*;
#(
  parameter int MaxEntries = DefMaxEntries,
  parameter int KeyBits = DefKeyBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [63:0] tenant_key,
  input  logic [63:0] quota_tokens,
  input  logic [63:0] usage_tokens,
  input  logic [19:0] rate_limit,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        allowed,
  output logic [63:0] quota_out,
  output logic [63:0] usage_out,
  output logic [19:0] rate_limit_out,
  output logic [8:0]  entries_used
);
  localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CW = $clog2(MaxEntries + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_SCAN = 8'b00000010, S_WAITK = 8'b00000100,
    S_CMP = 8'b00001000, S_RD = 8'b00010000, S_RDW = 8'b00100000,
    S_EXEC = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t state;
  logic [15:0] window_seconds;
  logic [2:0] op_r;
  logic [KeyBits-1:0] key_r;
  logic [63:0] quota_r, usage_r;
  logic [19:0] limit_r;
  logic [31:0] now_r;
  logic [CW-1:0] count, scan;
  logic [AW-1:0] slot;
  logic found;

  logic key_we, rec_we;
  logic [AW-1:0] key_waddr, rec_waddr, key_raddr, rec_raddr;
  logic [KeyBits-1:0] key_wdata, key_rdata;
  rec_t rec_wdata, rec_rdata, rec_hold;
  logic moving;
  logic exec_go;

  kqrl_ram #(.Width(KeyBits), .Depth(MaxEntries)) u_keys (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata));
  kqrl_ram #(.Width($bits(rec_t)), .Depth(MaxEntries)) u_recs (
    .clk, .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata));

  assign in_ready = (state == S_IDLE);
  // The last step runs once the previous result word has left the output register.
  assign exec_go = (state == S_EXEC) && (!out_valid || out_ready);
  assign entries_used = 9'(count);
  logic [CW-1:0] last;
  assign last = count - CW'(1);
  assign key_raddr = moving ? last[AW-1:0] : scan[AW-1:0];
  assign rec_raddr = moving ? last[AW-1:0] : slot;

  // Execution of the operation on the fetched record.
  logic [31:0] elapsed;
  logic restart;
  logic [19:0] wc_eff;
  assign elapsed = now_r - rec_hold.wstart;
  assign restart = elapsed >= {16'd0, window_seconds};
  assign wc_eff = restart ? 20'd0 : rec_hold.wcount;

  always_comb begin
    key_we = 1'b0;
    rec_we = 1'b0;
    key_waddr = slot;
    rec_waddr = slot;
    key_wdata = key_r;
    rec_wdata = rec_hold;
    if (exec_go && found) begin
      unique case (op_t'(op_r))
        OP_CREATE: begin
          key_we = 1'b1;
          rec_we = 1'b1;
          key_waddr = count[AW-1:0];
          rec_waddr = count[AW-1:0];
          rec_wdata = '{quota: quota_r, usage: usage_r, limit: limit_r,
                        wstart: 32'd0, wcount: 20'd0};
        end
        OP_UPDATE: begin
          rec_we = 1'b1;
          rec_wdata.quota = quota_r;
          rec_wdata.usage = usage_r;
          rec_wdata.limit = limit_r;
        end
        OP_DELETE: begin
          key_we = (CW'(slot) < last);
          rec_we = key_we;
          key_wdata = key_rdata;
          rec_wdata = rec_rdata;
        end
        OP_ADD: begin
          rec_we = 1'b1;
          rec_wdata.usage = rec_hold.usage + usage_r;
        end
        OP_CHK_RATE: begin
          rec_we = rec_hold.limit != 20'd0;
          if (restart) rec_wdata.wstart = now_r;
          rec_wdata.wcount = (wc_eff < rec_hold.limit) ? wc_eff + 20'd1 : wc_eff;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      window_seconds <= WindowReset;
      moving <= 1'b0;
    end else begin
      if (cfg_we) window_seconds <= cfg_wdata;
      if (out_valid && out_ready && !exec_go) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= operation;
            key_r <= tenant_key[KeyBits-1:0];
            quota_r <= quota_tokens;
            usage_r <= usage_tokens;
            limit_r <= rate_limit;
            now_r <= now_seconds;
            scan <= '0;
            found <= 1'b0;
            moving <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (op_t'(op_r) == OP_NONE || scan >= count) begin
            state <= S_RD;
          end else begin
            state <= S_WAITK;
          end
        end
        S_WAITK: state <= S_CMP;
        S_CMP: begin
          // Key read for entry "scan" is now valid.
          if (key_rdata == key_r) begin
            found <= 1'b1;
            slot <= scan[AW-1:0];
            state <= S_RD;
          end else begin
            scan <= scan + CW'(1);
            state <= S_SCAN;
          end
        end
        S_RD: begin
          moving <= 1'b0;
          state <= S_RDW;
        end
        S_RDW: begin
          rec_hold <= rec_rdata;
          // For delete, fetch the last entry next.
          moving <= 1'b1;
          state <= (op_t'(op_r) == OP_DELETE) ? S_OUT : S_EXEC;
          if (op_t'(op_r) == OP_CREATE) begin
            found <= (key_r != '0) && !found && (count < CW'(MaxEntries));
          end
        end
        S_OUT: state <= S_EXEC; // delete: last entry is read; its data arrives in S_EXEC
        S_EXEC: begin
          if (exec_go) begin
            moving <= 1'b0;
            status <= ST_OK;
            allowed <= 1'b0;
            quota_out <= '0;
            usage_out <= '0;
            rate_limit_out <= '0;
            unique case (op_t'(op_r))
              OP_CREATE: begin
                if (key_r == '0) status <= ST_BAD_KEY;
                else if (!found && scan < count) status <= ST_EXISTS;
                else if (!found) status <= ST_FULL;
                else count <= count + CW'(1);
              end
              OP_NONE: ;
              default: begin
                if (!found) status <= ST_MISSING;
                else begin
                  unique case (op_t'(op_r))
                    OP_GET: begin
                      quota_out <= rec_hold.quota;
                      usage_out <= rec_hold.usage;
                      rate_limit_out <= rec_hold.limit;
                    end
                    OP_DELETE: count <= last;
                    OP_CHK_QUOTA: allowed <= (rec_hold.quota == 64'd0) ||
                                             (rec_hold.usage < rec_hold.quota);
                    OP_CHK_RATE: allowed <= (rec_hold.limit == 20'd0) ||
                                            (wc_eff < rec_hold.limit);
                    default: ;
                  endcase
                end
              end
            endcase
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/kqrl_checker.sv @@
// Port-level checker for the keyed quota and rate-limit table, bound to it.
// Uses kqrl_pkg and the assertion macros header.
`include "keyed_quota_rate_limit_table_macros.svh"
module kqrl_checker
  import kqrl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       allowed,
  input logic [8:0] entries_used
);
  // A word accepted cannot be followed by another in the next cycle.
  `KQ_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)
  // A result word stays offered until it is taken.
  `KQ_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `KQ_ASSERT_IMP(a_allow_ok, clk, rst, out_valid && allowed, status == ST_OK)
  // The entry count only moves together with a new result word.
  `KQ_ASSERT_IMP(a_count, clk, rst, $changed(entries_used), out_valid)
endmodule

bind keyed_quota_rate_limit_table kqrl_checker u_kqrl_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .allowed,
  .entries_used);

@@ tb/keyed_quota_rate_limit_table_tb.sv @@
// Self-checking testbench for the keyed quota and rate-limit table.
// Depends on kqrl_pkg and keyed_quota_rate_limit_table; predicts every answer in a class.
module keyed_quota_rate_limit_table_tb;
  import kqrl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = DefMaxEntries;
  localparam int WatchdogLimit = 200000;

  typedef struct {
    op_t         op;
    logic [63:0] key;
    logic [63:0] quota;
    logic [63:0] usage;
    logic [19:0] limit;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic        allowed;
    logic [63:0] quota;
    logic [63:0] usage;
    logic [19:0] limit;
    logic [8:0]  used;
  } answer_t;

  class quota_table_scoreboard;
    logic [63:0] keys[Depth];
    logic [63:0] quotas[Depth];
    logic [63:0] usages[Depth];
    logic [19:0] limits[Depth];
    logic [31:0] wstarts[Depth];
    logic [19:0] wcounts[Depth];
    int          count;
    logic [15:0] window_len;
    answer_t     pending[$];
    int          mismatches;

    function new();
      count = 0;
      window_len = WindowReset;
      mismatches = 0;
    endfunction

    function int find_slot(logic [63:0] key);
      for (int i = 0; i < count; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function void note_request(request_t r);
      answer_t a;
      int      s;
      int      last;
      logic [31:0] elapsed;
      a = '{ST_OK, 1'b0, 64'd0, 64'd0, 20'd0, 9'd0};
      s = -1;
      if (r.op != OP_CREATE && r.op != OP_NONE) begin
        s = find_slot(r.key);
        if (s < 0) a.status = ST_MISSING;
      end
      case (r.op)
        OP_CREATE: begin
          if (r.key == 0) a.status = ST_BAD_KEY;
          else if (find_slot(r.key) >= 0) a.status = ST_EXISTS;
          else if (count >= Depth) a.status = ST_FULL;
          else begin
            keys[count] = r.key;
            quotas[count] = r.quota;
            usages[count] = r.usage;
            limits[count] = r.limit;
            wstarts[count] = '0;
            wcounts[count] = '0;
            count++;
          end
        end
        OP_GET: if (s >= 0) begin
          a.quota = quotas[s];
          a.usage = usages[s];
          a.limit = limits[s];
        end
        OP_UPDATE: if (s >= 0) begin
          quotas[s] = r.quota;
          usages[s] = r.usage;
          limits[s] = r.limit;
        end
        OP_DELETE: if (s >= 0) begin
          last = count - 1;
          keys[s] = keys[last];
          quotas[s] = quotas[last];
          usages[s] = usages[last];
          limits[s] = limits[last];
          wstarts[s] = wstarts[last];
          wcounts[s] = wcounts[last];
          count = last;
        end
        OP_ADD: if (s >= 0) usages[s] = usages[s] + r.usage;
        OP_CHK_QUOTA: if (s >= 0) a.allowed = (quotas[s] == 0) || (usages[s] < quotas[s]);
        OP_CHK_RATE: if (s >= 0) begin
          if (limits[s] == 0) a.allowed = 1'b1;
          else begin
            elapsed = r.now - wstarts[s];
            if (elapsed >= {16'd0, window_len}) begin
              wstarts[s] = r.now;
              wcounts[s] = '0;
            end
            if (wcounts[s] < limits[s]) begin
              wcounts[s] = wcounts[s] + 1'b1;
              a.allowed = 1'b1;
            end
          end
        end
        default: ;
      endcase
      a.used = count[8:0];
      pending.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, status %0d", got.status);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want st=%0d al=%0d q=%h u=%h l=%h n=%0d ",
                   want.status, want.allowed, want.quota, want.usage, want.limit, want.used,
                   "got st=%0d al=%0d q=%h u=%h l=%h n=%0d",
                   got.status, got.allowed, got.quota, got.usage, got.limit, got.used);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [63:0] tenant_key = '0;
  logic [63:0] quota_tokens = '0;
  logic [63:0] usage_tokens = '0;
  logic [19:0] rate_limit = '0;
  logic [31:0] now_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        allowed;
  logic [63:0] quota_out;
  logic [63:0] usage_out;
  logic [19:0] rate_limit_out;
  logic [8:0]  entries_used;

  quota_table_scoreboard board = new();
  bit   quiet_phase = 1'b0;
  bit   hold_off = 1'b0;
  int   idle_cycles = 0;
  logic [63:0] key_pool[16];
  logic [31:0] clock_now = 32'd1000;

  always #5 clk = ~clk;

  keyed_quota_rate_limit_table i_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .operation, .tenant_key,
    .quota_tokens, .usage_tokens, .rate_limit, .now_seconds, .out_valid, .out_ready,
    .status, .allowed, .quota_out, .usage_out, .rate_limit_out, .entries_used
  );

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && (quiet_phase || $urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_answer('{status_t'(status), allowed, quota_out, usage_out,
                           rate_limit_out, entries_used});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(request_t r);
    while (!quiet_phase && $urandom_range(99) < 10) @(posedge clk);
    in_valid <= 1'b1;
    operation <= r.op;
    tenant_key <= r.key;
    quota_tokens <= r.quota;
    usage_tokens <= r.usage;
    rate_limit <= r.limit;
    now_seconds <= r.now;
    do @(posedge clk); while (!in_ready);
    board.note_request(r);
    in_valid <= 1'b0;
    // The block stays busy after taking a word anyway.
    @(posedge clk);
  endtask

  task automatic drain_and_set_window(logic [15:0] w);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.window_len = w;
  endtask

  function automatic request_t make_req(op_t op, logic [63:0] key);
    request_t r;
    r.op = op;
    r.key = key;
    r.quota = {$urandom, $urandom};
    r.usage = {$urandom, $urandom};
    r.limit = 20'($urandom);
    r.now = $urandom;
    return r;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r = make_req(op_t'($urandom_range(6)), key_pool[$urandom_range(15)]);
    if (pick < 5) r.op = op_t'($urandom_range(7));
    if (pick < 3) r.key = {$urandom, $urandom};
    if (pick >= 50 && pick < 60) r.quota = 64'($urandom_range(3));
    if (pick >= 60 && pick < 70) r.limit = 20'($urandom_range(4));
    if (pick >= 70 && pick < 75) r.usage = '1;
    if (pick >= 90) r.limit = 20'($urandom_range(1));
    // Time mostly creeps forward so windows both hold and expire.
    clock_now = clock_now + $urandom_range(30);
    r.now = (pick < 95) ? clock_now : $urandom;
    return r;
  endfunction

  initial begin
    request_t r;
    logic [15:0] windows[4];
    int settle;
    windows = '{16'd0, 16'd1, 16'd65535, 16'd7};
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '1;
    key_pool[1] = 64'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero key, duplicate, extremes, each operation, unlimited cases.
    r = make_req(OP_CREATE, 64'd0); send_word(r);
    r = make_req(OP_GET, 64'd5); send_word(r);
    r = make_req(OP_CREATE, '1); r.quota = '1; r.usage = '1; r.limit = '1; send_word(r);
    r = make_req(OP_CREATE, '1); send_word(r);
    r = make_req(OP_GET, '1); send_word(r);
    r = make_req(OP_ADD, '1); r.usage = 64'd2; send_word(r);
    r = make_req(OP_CHK_QUOTA, '1); send_word(r);
    r = make_req(OP_CREATE, 64'd1); r.quota = '0; r.usage = '1; r.limit = '0; send_word(r);
    r = make_req(OP_CHK_QUOTA, 64'd1); send_word(r);
    r = make_req(OP_CHK_RATE, 64'd1); send_word(r);
    r = make_req(OP_UPDATE, 64'd1); r.limit = 20'd2; r.now = '0; send_word(r);
    for (int i = 0; i < 4; i++) begin
      r = make_req(OP_CHK_RATE, 64'd1); r.now = 32'hFFFF_FFF0 + i; send_word(r);
    end
    r = make_req(OP_NONE, 64'd1); send_word(r);
    r = make_req(OP_DELETE, '1); send_word(r);
    r = make_req(OP_GET, 64'd1); send_word(r);
    r = make_req(OP_DELETE, 64'd1); send_word(r);
    r = make_req(OP_DELETE, 64'd1); send_word(r);

    // Fill the table to the brim, then try one more create.
    for (int i = 0; i < Depth + 1; i++) begin
      r = make_req(OP_CREATE, 64'h100 + i);
      quiet_phase = (i < 100);
      send_word(r);
    end
    quiet_phase = 1'b0;
    r = make_req(OP_CHK_RATE, 64'h100 + Depth - 1); send_word(r);
    for (int i = 0; i < Depth; i++) begin
      r = make_req(OP_DELETE, 64'h100 + (i * 7) % Depth);
      send_word(r);
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_set_window(windows[phase]);
      quiet_phase = (phase == 2);
      if (phase == 1) begin
        hold_off = 1'b1;
        fork
          begin repeat (3000) @(posedge clk); hold_off = 1'b0; end
        join_none
      end
      for (int n = 0; n < 300; n++) send_word(random_req());
    end
    quiet_phase = 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 300) begin
      @(posedge clk);
      settle++;
    end
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ keyed_quota_rate_limit_table.f @@
+incdir+sv
sv/kqrl_pkg.sv
sv/kqrl_ram.sv
sv/keyed_quota_rate_limit_table.sv
sv/kqrl_checker.sv
tb/keyed_quota_rate_limit_table_tb.sv
